### rtl/cmr_pkg.sv
// Shared types and constants of the chunked message reassembler.
// Holds the port payload structs, result status codes and queue sizes.
// No dependencies; every other file imports this package.
package cmr_pkg;

  // Default store size; the top level hands it down as a parameter.
  localparam int DEF_STORE_DEPTH = 256;

  // Queue depths; both must be powers of two so the pointers wrap freely.
  localparam int IQ_DEPTH = 2;
  localparam int RQ_DEPTH = 4;

  // Value of func for the two item kinds.
  localparam logic FUNC_CHUNK = 1'b0;
  localparam logic FUNC_READ  = 1'b1;

  // Result status codes.
  localparam logic [2:0] ST_PARTIAL      = 3'd0;
  localparam logic [2:0] ST_DELIVERED    = 3'd1;
  localparam logic [2:0] ST_REPEAT_SUPP  = 3'd2;
  localparam logic [2:0] ST_CHUNK_REPEAT = 3'd3;
  localparam logic [2:0] ST_OUT_OF_SEQ   = 3'd4;
  localparam logic [2:0] ST_OVERFLOW     = 3'd5;
  localparam logic [2:0] ST_RUNT         = 3'd6;
  localparam logic [2:0] ST_READ         = 3'd7;

  // Input item as it appears on the port.
  typedef struct packed {
    logic       func;
    logic [7:0] data_byte;
    logic       chunk_start;
    logic       chunk_end;
    logic [7:0] read_index;
  } cmr_in_t;

  // Result item as it appears on the port.
  typedef struct packed {
    logic [2:0] status;
    logic [7:0] message_length;
    logic [7:0] connector;
    logic [7:0] read_data;
  } cmr_out_t;

  // Classified item passed from the front queue to the back engine.
  typedef struct packed {
    logic       is_read;
    logic       is_start;
    logic       is_last;
    logic [7:0] data_byte;
    logic [7:0] read_index;
  } cmr_item_t;

endpackage

### rtl/cmr_front.sv
// Front end of the reassembler: accepts input items and classifies them.
// A two-entry queue decouples the input port from the back engine.
// Depends on cmr_pkg.
module cmr_front import cmr_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  output logic      full,
  input  cmr_in_t   in_item,
  output logic      q_valid,
  output cmr_item_t q_item,
  input  logic      q_pop
);

  localparam int PW = $clog2(IQ_DEPTH);
  localparam logic [PW:0] IQ_FULL = (PW + 1)'(IQ_DEPTH);

  cmr_item_t     slot_r [IQ_DEPTH];
  logic [PW-1:0] wr_ptr_r;
  logic [PW-1:0] rd_ptr_r;
  logic [PW:0]   count_r;
  logic [PW:0]   count_nxt;
  cmr_item_t     cls;
  logic          do_push;

  // Classify: split read requests from chunk bytes.
  always_comb begin
    cls.is_read    = (in_item.func == FUNC_READ);
    cls.is_start   = in_item.chunk_start;
    cls.is_last    = in_item.chunk_end;
    cls.data_byte  = in_item.data_byte;
    cls.read_index = in_item.read_index;
  end

  assign full    = (count_r == IQ_FULL);
  assign do_push = push && !full;
  assign q_valid = (count_r != '0);
  assign q_item  = slot_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (do_push && !q_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!do_push && q_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (q_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_nxt;
    end
  end

endmodule

### rtl/cmr_back.sv
// Back engine of the reassembler: header checks, message store and verdicts.
// One item per cycle while the result queue has room; a second register stage
// carries the result and store read. Depends on cmr_pkg.
module cmr_back import cmr_pkg::*; #(
  parameter int STORE_DEPTH = DEF_STORE_DEPTH
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_valid,
  input  cmr_item_t                     q_item,
  output logic                          q_pop,
  input  logic [7:0]                    conn_num,
  input  logic [$clog2(RQ_DEPTH+1)-1:0] rq_count,
  output logic                          res_valid,
  output cmr_out_t                      res
);

  localparam int AW  = $clog2(STORE_DEPTH);
  localparam int CW  = ((AW > 16) ? AW : 16) + 1;
  localparam int RCW = $clog2(RQ_DEPTH + 1);
  localparam logic [CW-1:0]  DEPTH_C = CW'(STORE_DEPTH);
  localparam logic [RCW:0]   RQ_CAP  = (RCW + 1)'(RQ_DEPTH);
  localparam logic [15:0]    PC_MAX  = 16'hFFFF;

  localparam logic [1:0] VRD_PENDING = 2'd0;
  localparam logic [1:0] VRD_ACCEPT  = 2'd1;
  localparam logic [1:0] VRD_REPEAT  = 2'd2;
  localparam logic [1:0] VRD_OUTSEQ  = 2'd3;

  // Message state.
  logic [AW-1:0] wp_r, wp_nxt;
  logic [7:0]    exp_len_r, exp_len_nxt;
  logic [7:0]    cur_seq_r, cur_seq_nxt;
  logic [7:0]    exp_chunk_r, exp_chunk_nxt;
  logic [7:0]    lds_r, lds_nxt;
  logic [7:0]    bic_r, bic_nxt;
  logic [7:0]    inc_seq_r, inc_seq_nxt;
  logic          acc_r, acc_nxt;
  logic          open_r, open_nxt;
  logic          first_r, first_nxt;
  logic [1:0]    verd_r, verd_nxt;
  logic [15:0]   pc_r, pc_nxt;

  // Per-item working values.
  logic          fire;
  logic [7:0]    k;
  logic [7:0]    d;
  logic          hdr_done;
  logic [CW-1:0] pos;
  logic [CW-1:0] end_pos;
  logic [CW-1:0] ridx_ext;
  logic          st_we;
  logic [AW-1:0] st_waddr;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic          res_v;
  cmr_out_t      res_nxt;

  // Result stage.
  logic          s2_valid_r;
  cmr_out_t      s2_res_r;
  logic          s2_rd_sel_r;
  logic [7:0]    rd_q_r;

  logic [7:0]    store_mem [STORE_DEPTH];

  // Take an item only if the result queue can absorb it with the one in flight.
  assign fire  = q_valid && (((RCW + 1)'(rq_count) + (RCW + 1)'(s2_valid_r)) < RQ_CAP);
  assign q_pop = fire;
  assign d     = q_item.data_byte;

  always_comb begin
    wp_nxt        = wp_r;
    exp_len_nxt   = exp_len_r;
    cur_seq_nxt   = cur_seq_r;
    exp_chunk_nxt = exp_chunk_r;
    lds_nxt       = lds_r;
    bic_nxt       = bic_r;
    inc_seq_nxt   = inc_seq_r;
    acc_nxt       = acc_r;
    open_nxt      = open_r;
    first_nxt     = first_r;
    verd_nxt      = verd_r;
    pc_nxt        = pc_r;
    k             = '0;
    hdr_done      = 1'b0;
    pos           = '0;
    end_pos       = '0;
    st_we         = 1'b0;
    st_waddr      = '0;
    res_v         = 1'b0;
    res_nxt       = '0;
    ridx_ext      = CW'(q_item.read_index);
    rd_addr       = ridx_ext[AW-1:0];
    rd_en         = 1'b0;

    if (fire) begin
      if (q_item.is_read) begin
        res_v          = 1'b1;
        res_nxt.status = ST_READ;
        rd_en          = (ridx_ext < DEPTH_C);
      end else begin
        if (q_item.is_start) begin
          open_nxt  = 1'b1;
          bic_nxt   = '0;
          pc_nxt    = '0;
          acc_nxt   = 1'b0;
          first_nxt = 1'b0;
          verd_nxt  = VRD_PENDING;
        end
        if (open_nxt) begin
          k = bic_nxt;
          if (k == 8'd0) begin
            inc_seq_nxt = d;
          end else if (k == 8'd1) begin
            if (d == 8'd0) begin
              first_nxt = 1'b1;
            end else if (cur_seq_nxt == inc_seq_nxt && d <= exp_chunk_nxt) begin
              if (d == exp_chunk_nxt) begin
                acc_nxt  = 1'b1;
                verd_nxt = VRD_ACCEPT;
              end else begin
                verd_nxt = VRD_REPEAT;
              end
            end else begin
              exp_len_nxt = '0;
              verd_nxt    = VRD_OUTSEQ;
            end
          end else if (k == 8'd2 && first_nxt) begin
            // Length byte of a first chunk: restart the message.
            exp_len_nxt   = d;
            cur_seq_nxt   = inc_seq_nxt;
            exp_chunk_nxt = '0;
            wp_nxt        = '0;
            acc_nxt       = 1'b1;
            verd_nxt      = VRD_ACCEPT;
          end else begin
            hdr_done = first_nxt ? (k >= 8'd3) : (k >= 8'd2);
            if (hdr_done && acc_nxt) begin
              // Write speculatively; drop bytes past the end of the store.
              pos = CW'(wp_nxt) + CW'(pc_nxt);
              if (pos < DEPTH_C) begin
                st_we    = 1'b1;
                st_waddr = pos[AW-1:0];
              end
              if (pc_nxt != PC_MAX) begin
                pc_nxt = pc_nxt + 16'd1;
              end
            end
          end
          if (bic_nxt != 8'hFF) begin
            bic_nxt = bic_nxt + 8'd1;
          end

          if (q_item.is_last) begin
            open_nxt = 1'b0;
            res_v    = 1'b1;
            if (k == 8'd0 || (k == 8'd1 && first_nxt)) begin
              res_nxt.status = ST_RUNT;
            end else if (verd_nxt == VRD_REPEAT) begin
              res_nxt.status = ST_CHUNK_REPEAT;
            end else if (verd_nxt != VRD_ACCEPT) begin
              res_nxt.status = ST_OUT_OF_SEQ;
            end else begin
              end_pos = CW'(wp_nxt) + CW'(pc_nxt);
              if (end_pos >= DEPTH_C) begin
                wp_nxt         = '0;
                exp_len_nxt    = '0;
                res_nxt.status = ST_OVERFLOW;
              end else begin
                exp_chunk_nxt = exp_chunk_nxt + 8'd1;
                if (end_pos == CW'(exp_len_nxt)) begin
                  wp_nxt = '0;
                  if (cur_seq_nxt != lds_nxt) begin
                    lds_nxt                = cur_seq_nxt;
                    res_nxt.status         = ST_DELIVERED;
                    res_nxt.message_length = exp_len_nxt;
                    res_nxt.connector      = conn_num;
                  end else begin
                    res_nxt.status = ST_REPEAT_SUPP;
                  end
                  exp_len_nxt = '0;
                end else begin
                  wp_nxt         = end_pos[AW-1:0];
                  res_nxt.status = ST_PARTIAL;
                end
              end
            end
          end
        end
      end
    end
  end

  // Message store: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (st_we) begin
      store_mem[st_waddr] <= d;
    end
    if (rd_en) begin
      rd_q_r <= store_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    s2_res_r    <= res_nxt;
    s2_rd_sel_r <= rd_en;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r        <= '0;
      exp_len_r   <= '0;
      cur_seq_r   <= '0;
      exp_chunk_r <= '0;
      lds_r       <= 8'hFF;
      bic_r       <= '0;
      inc_seq_r   <= '0;
      acc_r       <= 1'b0;
      open_r      <= 1'b0;
      first_r     <= 1'b0;
      verd_r      <= VRD_PENDING;
      pc_r        <= '0;
      s2_valid_r  <= 1'b0;
    end else begin
      wp_r        <= wp_nxt;
      exp_len_r   <= exp_len_nxt;
      cur_seq_r   <= cur_seq_nxt;
      exp_chunk_r <= exp_chunk_nxt;
      lds_r       <= lds_nxt;
      bic_r       <= bic_nxt;
      inc_seq_r   <= inc_seq_nxt;
      acc_r       <= acc_nxt;
      open_r      <= open_nxt;
      first_r     <= first_nxt;
      verd_r      <= verd_nxt;
      pc_r        <= pc_nxt;
      s2_valid_r  <= res_v;
    end
  end

  assign res_valid = s2_valid_r;

  always_comb begin
    res           = s2_res_r;
    res.read_data = s2_rd_sel_r ? rd_q_r : 8'h00;
  end

endmodule

### rtl/cmr_rq.sv
// Result queue of the reassembler: holds finished results until popped.
// Presents the oldest entry and reports its fill count to the back engine.
// Depends on cmr_pkg.
module cmr_rq import cmr_pkg::*; (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          res_valid,
  input  cmr_out_t                      res,
  output logic [$clog2(RQ_DEPTH+1)-1:0] rq_count,
  output logic                          empty,
  input  logic                          pop,
  output cmr_out_t                      out_item
);

  localparam int PW  = $clog2(RQ_DEPTH);
  localparam int RCW = $clog2(RQ_DEPTH + 1);

  cmr_out_t       slot_r [RQ_DEPTH];
  logic [PW-1:0]  wr_ptr_r;
  logic [PW-1:0]  rd_ptr_r;
  logic [RCW-1:0] count_r;
  logic [RCW-1:0] count_nxt;
  logic           do_pop;

  assign empty    = (count_r == '0);
  assign do_pop   = pop && !empty;
  assign out_item = slot_r[rd_ptr_r];
  assign rq_count = count_r;

  always_comb begin
    count_nxt = count_r;
    if (res_valid && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!res_valid && do_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      slot_r[wr_ptr_r] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (res_valid) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_nxt;
    end
  end

endmodule

### rtl/chunked_message_reassembler_unit.sv
// Path: front queue, back result register, result queue. One item per cycle while
// the result queue has room; the back engine updates all header state per byte.
// The store has one write and one registered read port, so reads never stall bytes.
// Reset (rst_n low, synchronous) empties both queues and restores the header state;
// the message store keeps its contents and is undefined until written.
// Depends on cmr_pkg, cmr_front, cmr_back and cmr_rq.
module chunked_message_reassembler_unit import cmr_pkg::*; #(
  parameter int STORE_DEPTH = DEF_STORE_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  // Input queue side
  input  logic       push,
  output logic       full,
  input  cmr_in_t    in_item,
  // Result queue side
  output logic       empty,
  input  logic       pop,
  output cmr_out_t   out_item,
  // Configuration write channel (connector number)
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_data
);

  localparam int RCW = $clog2(RQ_DEPTH + 1);

  logic           q_valid;
  cmr_item_t      q_item;
  logic           q_pop;
  logic           res_valid;
  cmr_out_t       res;
  logic [RCW-1:0] rq_count;
  logic [7:0]     conn_num_r;

  // The register may be written only while the block is idle; the user keeps to that, so take every transfer.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      conn_num_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      conn_num_r <= cfg_data;
    end
  end

  // Front: accept and classify, hold up to two items.
  cmr_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .full    (full),
    .in_item (in_item),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_pop   (q_pop)
  );

  // Back: header checks, store writes and reads, one verdict per chunk end.
  cmr_back #(
    .STORE_DEPTH (STORE_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .conn_num  (conn_num_r),
    .rq_count  (rq_count),
    .res_valid (res_valid),
    .res       (res)
  );

  // Result queue: hold finished results until the consumer pops them.
  cmr_rq u_rq (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res       (res),
    .rq_count  (rq_count),
    .empty     (empty),
    .pop       (pop),
    .out_item  (out_item)
  );

endmodule

### rtl/cmr_checker.sv
// Port-level checks for the chunked message reassembler.
// Bound to chunked_message_reassembler_unit; depends on cmr_pkg.
module cmr_checker import cmr_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       push,
  input logic       full,
  input cmr_in_t    in_item,
  input logic       empty,
  input logic       pop,
  input cmr_out_t   out_item,
  input logic       cfg_valid,
  input logic       cfg_ready,
  input logic [7:0] cfg_data
);

  // Reset drains both queues.
  a_reset_drains: assert property (@(posedge clk) !rst_n |=> (empty && !full))
    else $error("queues not drained by reset");

  // A waiting result holds until it is popped.
  a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_item)))
    else $error("waiting result changed before pop");

  // Only a delivered message carries a length and a connector number.
  a_delivery_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_item.status != ST_DELIVERED) |->
      (out_item.message_length == 8'h00 && out_item.connector == 8'h00))
    else $error("length or connector on a result that is no delivery");

  // Only a read result carries store data.
  a_read_field: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_item.status != ST_READ) |-> (out_item.read_data == 8'h00))
    else $error("read data on a result that is no read");

endmodule

bind chunked_message_reassembler_unit cmr_checker u_cmr_checker (.*);

### verif/chunked_message_reassembler_unit_test.sv
// Self-checking testbench of chunked_message_reassembler_unit: directed chunk cases,
// then random message traffic with random stalls on both queue sides.
// Depends on cmr_pkg and the RTL of the unit; reads and writes no files.
module chunked_message_reassembler_unit_test;
  import cmr_pkg::*;

  localparam int DEPTH = DEF_STORE_DEPTH;
  // Covers the pipeline plus the input queue; wait this long before a
  // register write so that chunk bytes without a result have drained too.
  localparam int SETTLE_CYCLES = 8;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int RANDOM_PHASES = 5;
  localparam int PHASE_ITEMS = 120;

  typedef enum logic [1:0] {
    CHUNK_UNDECIDED, CHUNK_TAKEN, CHUNK_REPEATED, CHUNK_STRAY
  } chunk_verdict_t;

  typedef enum logic [1:0] {PACE_BURST, PACE_SLOW, PACE_LIGHT} pace_t;

  typedef enum logic [1:0] {
    FAULT_REPEAT, FAULT_SKIP, FAULT_WRONG_SEQ, FAULT_ABANDON
  } fault_t;

  logic     clk = 1'b0;
  logic     rst_n;
  logic     push;
  logic     full;
  cmr_in_t  in_item;
  logic     empty;
  logic     pop;
  cmr_out_t out_item;
  logic     cfg_valid;
  logic     cfg_ready;
  logic [7:0] cfg_data;

  chunked_message_reassembler_unit #(.STORE_DEPTH(DEPTH)) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .in_item   (in_item),
    .empty     (empty),
    .pop       (pop),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Reassembly predictor: a private copy of the header state and the store.
  // ---------------------------------------------------------------------------
  bit [7:0]       stored_bytes [DEPTH];
  int unsigned    fill_pos = 0;        // store position of the next message byte
  bit [7:0]       msg_length = 8'd0;   // length announced by chunk zero
  bit [7:0]       msg_seq = 8'd0;      // sequence of the message being built
  bit [7:0]       next_chunk = 8'd0;   // chunk id that is accepted next
  bit [7:0]       delivered_seq = 8'd255;
  bit [7:0]       byte_count = 8'd0;   // position inside the open chunk, saturating
  bit [7:0]       hdr_seq = 8'd0;      // sequence byte of the open chunk
  bit             chunk_ok = 1'b0;     // payload of the open chunk goes to the store
  bit             in_chunk = 1'b0;
  bit             opens_message = 1'b0;
  chunk_verdict_t chunk_verdict = CHUNK_UNDECIDED;
  int unsigned    payload_bytes = 0;
  bit [7:0]       connector_reg = 8'd0;

  cmr_out_t expected_results [$];

  int mismatch_count = 0;
  int items_taken = 0;
  int cycle_count = 0;
  pace_t in_pace = PACE_BURST;
  int in_run_left = 0;
  bit [7:0] last_msg_seq = 8'd0;

  function automatic void post_result(logic [2:0] status, logic [7:0] length,
                                      logic [7:0] connector, logic [7:0] rdata);
    cmr_out_t r;
    r.status = status;
    r.message_length = length;
    r.connector = connector;
    r.read_data = rdata;
    expected_results.push_back(r);
  endfunction

  // Decide the fate of a chunk at its last byte.
  function automatic void close_chunk();
    int unsigned end_pos;
    bit [7:0] length;
    if (chunk_verdict == CHUNK_REPEATED) begin
      post_result(ST_CHUNK_REPEAT, 8'd0, 8'd0, 8'd0);
      return;
    end
    if (chunk_verdict != CHUNK_TAKEN) begin
      post_result(ST_OUT_OF_SEQ, 8'd0, 8'd0, 8'd0);
      return;
    end
    end_pos = fill_pos + payload_bytes;
    if (end_pos >= DEPTH) begin
      // Drop the message; bytes already written stay in the store.
      fill_pos = 0;
      msg_length = 8'd0;
      post_result(ST_OVERFLOW, 8'd0, 8'd0, 8'd0);
      return;
    end
    fill_pos = end_pos;
    next_chunk = next_chunk + 8'd1;
    if (fill_pos == msg_length) begin
      length = msg_length;
      fill_pos = 0;
      msg_length = 8'd0;
      if (msg_seq != delivered_seq) begin
        delivered_seq = msg_seq;
        post_result(ST_DELIVERED, length, connector_reg, 8'd0);
      end else begin
        post_result(ST_REPEAT_SUPP, 8'd0, 8'd0, 8'd0);
      end
    end else begin
      post_result(ST_PARTIAL, 8'd0, 8'd0, 8'd0);
    end
  endfunction

  // Advance the predictor by one transferred item; return 0 if the block
  // ignores the item (a stray byte outside any chunk).
  function automatic bit reassemble_step(cmr_in_t it);
    bit [7:0] k;
    bit [7:0] d;
    int unsigned hdr_len;
    int unsigned pos;
    d = it.data_byte;
    if (it.func == FUNC_READ) begin
      post_result(ST_READ, 8'd0, 8'd0, stored_bytes[it.read_index]);
      return 1'b1;
    end
    if (it.chunk_start) begin
      // A new start abandons any open chunk; its header effects remain.
      in_chunk = 1'b1;
      byte_count = 8'd0;
      payload_bytes = 0;
      chunk_ok = 1'b0;
      opens_message = 1'b0;
      chunk_verdict = CHUNK_UNDECIDED;
    end
    if (!in_chunk) return 1'b0;

    k = byte_count;
    if (k == 8'd0) begin
      hdr_seq = d;
    end else if (k == 8'd1) begin
      if (d == 8'd0) begin
        opens_message = 1'b1;
      end else if (msg_seq == hdr_seq && d <= next_chunk) begin
        if (d == next_chunk) begin
          chunk_ok = 1'b1;
          chunk_verdict = CHUNK_TAKEN;
        end else begin
          chunk_verdict = CHUNK_REPEATED;
        end
      end else begin
        // Wrong sequence or skipped chunk: forget the announced length.
        msg_length = 8'd0;
        chunk_verdict = CHUNK_STRAY;
      end
    end else if (k == 8'd2 && opens_message) begin
      // Restart the message at the length byte of chunk zero.
      msg_length = d;
      msg_seq = hdr_seq;
      next_chunk = 8'd0;
      fill_pos = 0;
      chunk_ok = 1'b1;
      chunk_verdict = CHUNK_TAKEN;
    end else begin
      hdr_len = opens_message ? 3 : 2;
      if (k >= hdr_len && chunk_ok) begin
        // Write speculatively; drop bytes past the end of the store.
        pos = fill_pos + payload_bytes;
        if (pos < DEPTH) stored_bytes[pos] = d;
        if (payload_bytes < 32'hFFFF) payload_bytes++;
      end
    end
    if (byte_count < 8'd255) byte_count++;

    if (!it.chunk_end) return 1'b1;
    in_chunk = 1'b0;
    if (k == 8'd0 || (k == 8'd1 && opens_message)) begin
      post_result(ST_RUNT, 8'd0, 8'd0, 8'd0);
    end else begin
      close_chunk();
    end
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Pacing, stimulus and register access
  // ---------------------------------------------------------------------------
  function automatic int wait_cycles(pace_t pace);
    unique case (pace)
      PACE_BURST: return 0;
      PACE_SLOW:  return $urandom_range(0, 18);
      default:    return $urandom_range(0, 3);
    endcase
  endfunction

  // Transfer one item into the block and predict what it causes.
  task automatic send_item(cmr_in_t it);
    int gap;
    if (in_run_left == 0) begin
      in_pace = pace_t'($urandom_range(0, 2));
      in_run_left = $urandom_range(10, 60);
    end
    in_run_left--;
    gap = wait_cycles(in_pace);
    // Hold push high across back-to-back items; lower it only for a gap.
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (full) @(posedge clk);
    if (reassemble_step(it)) items_taken++;
  endtask

  task automatic send_byte(bit [7:0] d, bit first, bit last);
    cmr_in_t it;
    it.func = FUNC_CHUNK;
    it.data_byte = d;
    it.chunk_start = first;
    it.chunk_end = last;
    it.read_index = 8'($urandom_range(0, 255));
    send_item(it);
  endtask

  // Send one chunk: header, then npay random payload bytes. With closed low
  // the last byte carries no end mark and the chunk stays open.
  task automatic send_chunk(bit [7:0] seq, bit [7:0] cid, bit [7:0] total, int npay,
                            bit closed);
    bit [7:0] hdr [$];
    bit [7:0] b;
    int nb;
    hdr.push_back(seq);
    hdr.push_back(cid);
    if (cid == 8'd0) hdr.push_back(total);
    nb = hdr.size() + npay;
    for (int i = 0; i < nb; i++) begin
      if (i < hdr.size()) b = hdr[i];
      else b = 8'($urandom_range(0, 255));
      send_byte(b, i == 0, closed && i == nb - 1);
    end
  endtask

  // A chunk that ends before its header is complete.
  task automatic send_runt(bit two_bytes);
    send_byte(8'($urandom_range(0, 255)), 1'b1, !two_bytes);
    if (two_bytes) send_byte(8'h00, 1'b0, 1'b1);
  endtask

  task automatic send_read(bit [7:0] idx);
    cmr_in_t it;
    it.func = FUNC_READ;
    it.data_byte = 8'($urandom_range(0, 255));
    it.chunk_start = 1'($urandom_range(0, 1));
    it.chunk_end = 1'($urandom_range(0, 1));
    it.read_index = idx;
    send_item(it);
  endtask

  // Send a well-formed message split into random chunks; a faulty message
  // may carry a repeated, skipped, foreign or abandoned chunk.
  task automatic send_message(bit [7:0] seq, int total, bit faulty);
    int left;
    int n;
    int max_chunk;
    bit [7:0] cid;
    fault_t fault;
    max_chunk = (total > 40) ? 64 : 12;
    left = total;
    n = $urandom_range(0, (left < max_chunk) ? left : max_chunk);
    send_chunk(seq, 8'd0, 8'(total), n, 1'b1);
    left -= n;
    cid = 8'd0;
    while (left > 0) begin
      cid++;
      n = $urandom_range(1, (left < max_chunk) ? left : max_chunk);
      if (faulty && $urandom_range(0, 4) == 0) begin
        fault = fault_t'($urandom_range(0, 3));
        unique case (fault)
          FAULT_REPEAT: begin
            if (cid > 8'd1) send_chunk(seq, cid - 8'd1, 8'd0, n, 1'b1);
          end
          FAULT_SKIP: begin
            send_chunk(seq, cid + 8'd1, 8'd0, n, 1'b1);
            return;
          end
          FAULT_WRONG_SEQ: begin
            send_chunk(seq ^ 8'h01, cid, 8'd0, n, 1'b1);
            return;
          end
          default: send_chunk(seq, cid, 8'd0, n, 1'b0);
        endcase
      end
      send_chunk(seq, cid, 8'd0, n, 1'b1);
      left -= n;
    end
  endtask

  // Drop push, wait for every expected result, then let stray bytes drain.
  task automatic wait_idle();
    push <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_connector(bit [7:0] value);
    wait_idle();
    cfg_data <= value;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    connector_reg = value;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Bytes with no chunk open are ignored and give no result.
  task automatic test_stray_bytes();
    send_byte(8'h00, 1'b0, 1'b0);
    send_byte(8'hFF, 1'b0, 1'b1);
  endtask

  // One chunk far longer than the store: the byte position saturates, the
  // payload fills every store entry and the chunk ends in an overflow.
  task automatic test_long_chunk();
    send_chunk(8'hA5, 8'd0, 8'd200, 300, 1'b1);
  endtask

  task automatic test_runts();
    send_runt(1'b0);
    send_runt(1'b1);
  endtask

  // Delivery with the reset connector, a suppressed repeat of the same
  // sequence, and an empty message with the highest connector number.
  task automatic test_delivery();
    send_chunk(8'h01, 8'd0, 8'd10, 4, 1'b1);
    send_chunk(8'h01, 8'd1, 8'd0, 3, 1'b1);
    send_chunk(8'h01, 8'd2, 8'd0, 3, 1'b1);
    write_connector(8'hFF);
    send_chunk(8'h01, 8'd0, 8'd3, 3, 1'b1);
    send_chunk(8'hFF, 8'd0, 8'd0, 0, 1'b1);
  endtask

  // Repeated chunk, skipped chunk, foreign sequence, then a chunk accepted
  // after the length was cleared.
  task automatic test_chunk_errors();
    send_chunk(8'h03, 8'd0, 8'd20, 5, 1'b1);
    send_chunk(8'h03, 8'd1, 8'd0, 5, 1'b1);
    send_chunk(8'h03, 8'd1, 8'd0, 3, 1'b1);
    send_chunk(8'h03, 8'd4, 8'd0, 2, 1'b1);
    send_chunk(8'h09, 8'd2, 8'd0, 2, 1'b1);
    send_chunk(8'h03, 8'd2, 8'd0, 10, 1'b1);
  endtask

  // A chunk start inside an open chunk abandons it.
  task automatic test_restart_inside();
    send_chunk(8'h07, 8'd0, 8'd6, 3, 1'b0);
    send_chunk(8'h07, 8'd0, 8'd6, 2, 1'b1);
    send_chunk(8'h07, 8'd1, 8'd0, 2, 1'b0);
    send_chunk(8'h07, 8'd1, 8'd0, 4, 1'b1);
  endtask

  // Every store entry has been written by the long chunk by now.
  task automatic test_reads();
    send_read(8'h00);
    send_read(8'hFF);
    send_read(8'h55);
    send_read(8'hAA);
  endtask

  task automatic test_random_traffic();
    int phase_base;
    int pick;
    int total;
    bit [7:0] seq;
    cmr_in_t it;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      if (phase == 0) write_connector(8'h00);
      else if (phase == 1) write_connector(8'hFF);
      else write_connector(8'($urandom_range(0, 255)));
      phase_base = items_taken;
      while (items_taken - phase_base < PHASE_ITEMS) begin
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
          // Reuse the last sequence now and then to hit repeat suppression.
          seq = ($urandom_range(0, 3) == 0) ? last_msg_seq : 8'($urandom_range(0, 255));
          last_msg_seq = seq;
          total = ($urandom_range(0, 19) == 0) ? $urandom_range(100, 255)
                                               : $urandom_range(0, 24);
          send_message(seq, total, $urandom_range(0, 3) == 0);
        end else if (pick < 70) begin
          send_read(8'($urandom_range(0, 255)));
        end else if (pick < 78) begin
          send_runt(1'($urandom_range(0, 1)));
        end else if (pick < 90) begin
          seq = $urandom_range(0, 1) ? last_msg_seq : 8'($urandom_range(0, 255));
          send_chunk(seq, 8'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                     $urandom_range(0, 6), $urandom_range(0, 4) != 0);
        end else begin
          it.func = FUNC_CHUNK;
          it.data_byte = 8'($urandom_range(0, 255));
          it.chunk_start = 1'($urandom_range(0, 1));
          it.chunk_end = 1'($urandom_range(0, 1));
          it.read_index = 8'($urandom_range(0, 255));
          send_item(it);
        end
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random pop stalls, and the check of every transfer out.
  // ---------------------------------------------------------------------------
  initial begin : result_drain
    pace_t pace;
    int run_left;
    int stall;
    pace = PACE_BURST;
    run_left = 0;
    pop <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (run_left == 0) begin
        pace = pace_t'($urandom_range(0, 2));
        run_left = $urandom_range(10, 60);
      end
      run_left--;
      stall = wait_cycles(pace);
      if (stall > 0) begin
        pop <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      pop <= 1'b1;
      @(posedge clk);
      while (empty) @(posedge clk);
    end
  end

  function automatic void report_mismatch(string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("%s", msg);
  endfunction

  always @(posedge clk) begin : check_results
    cmr_out_t want;
    if (rst_n && pop && !empty) begin
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf(
          "unexpected result: st=%0d len=%0d conn=%0d rd=%0d",
          out_item.status, out_item.message_length, out_item.connector,
          out_item.read_data));
      end else begin
        want = expected_results.pop_front();
        if (out_item.status !== want.status ||
            out_item.message_length !== want.message_length ||
            out_item.connector !== want.connector ||
            out_item.read_data !== want.read_data) begin
          report_mismatch({
            $sformatf("result mismatch: expected st=%0d len=%0d conn=%0d rd=%0d",
                      want.status, want.message_length, want.connector,
                      want.read_data),
            $sformatf(", got st=%0d len=%0d conn=%0d rd=%0d",
                      out_item.status, out_item.message_length, out_item.connector,
                      out_item.read_data)});
        end
      end
    end
  end

  // Stop a hung run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    rst_n <= 1'b0;
    push <= 1'b0;
    in_item <= '0;
    cfg_valid <= 1'b0;
    cfg_data <= 8'd0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    test_stray_bytes();
    test_long_chunk();
    test_runts();
    test_delivery();
    test_chunk_errors();
    test_restart_inside();
    test_reads();
    test_random_traffic();

    // Drain everything, then keep waiting for stray results before the verdict.
    wait_idle();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

### sim.f
rtl/cmr_pkg.sv
rtl/cmr_front.sv
rtl/cmr_back.sv
rtl/cmr_rq.sv
rtl/chunked_message_reassembler_unit.sv
rtl/cmr_checker.sv
verif/chunked_message_reassembler_unit_test.sv
